[rtl/lkx_pkg.sv]
// ----------------------------------------------------------------------------
// lkx_pkg
// shared types and constants of the per-client keystream codec
// ----------------------------------------------------------------------------
package lkx_pkg;

  localparam int KEY_W  = 32;
  localparam int DATA_W = 16;

  localparam logic [KEY_W-1:0] LCG_MUL = 32'd214015;
  localparam logic [KEY_W-1:0] LCG_ADD = 32'd2531077;

  typedef enum logic [2:0] {
    OP_ENCODE    = 3'd0,
    OP_DECODE    = 3'd1,
    OP_PEEK      = 3'd2,
    OP_LOAD_SEND = 3'd3,
    OP_LOAD_RECV = 3'd4
  } opcode_t;

endpackage

[rtl/lkx_ram.sv]
// ----------------------------------------------------------------------------
// lkx_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module lkx_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 256,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/lkx_step.sv]
// ----------------------------------------------------------------------------
// lkx_step
// key advance and keystream xor of one word or final byte
// ----------------------------------------------------------------------------
module lkx_step
  import lkx_pkg::*;
(
  input  logic [KEY_W-1:0]  key,
  input  logic [DATA_W-1:0] data_in,
  input  logic              odd_byte,
  output logic [KEY_W-1:0]  key_next,
  output logic [DATA_W-1:0] data_out
);

  logic [DATA_W-1:0] ks;
  logic [DATA_W-1:0] mixed;

  always_comb begin
    key_next = key * LCG_MUL + LCG_ADD;
    ks       = key_next[KEY_W-1:KEY_W-DATA_W];
    mixed    = data_in ^ ks;
    if (odd_byte) begin
      data_out = {8'd0, mixed[7:0]};
    end else begin
      data_out = mixed;
    end
  end

endmodule

[rtl/lcg_keystream_xor_codec_top.sv]
// ----------------------------------------------------------------------------
// lcg_keystream_xor_codec_top
// per-client keystream cipher: send and receive keys held in two rams,
// read, advanced and written back for each encode or decode word
//
//   channel  handshake             payload
//   in       in_valid / in_stall   opcode, client, data_in, odd_byte, key_value
//   out      out_valid / out_stall data_out
//
// encode, decode and peek first read the key ram, then update the key and, for
// encode and decode, write it back; key loads write the ram when accepted
// a new word is taken while a result still waits in the output register
// a stalled output holds the update cycle until the output register frees
// reset clears control state only and stalls the input while it is high;
// key rams hold nothing until loaded
// ----------------------------------------------------------------------------
module lcg_keystream_xor_codec_top
  import lkx_pkg::*;
#(
  parameter int CLIENTS = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        opcode,
  input  logic [7:0]        client,
  input  logic [DATA_W-1:0] data_in,
  input  logic              odd_byte,
  input  logic [KEY_W-1:0]  key_value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [DATA_W-1:0] data_out
);

  localparam int ADDR_W = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;

  typedef enum logic {
    S_IDLE,
    S_CALC
  } state_t;

  state_t            state;
  opcode_t           op_q;
  logic [ADDR_W-1:0] addr_q;
  logic [DATA_W-1:0] data_q;
  logic              odd_q;

  opcode_t           op_in;
  logic              accept;
  logic              in_range;
  logic [ADDR_W-1:0] addr_in;
  logic [ADDR_W-1:0] raddr;
  logic              out_free;
  logic              finish;

  logic              send_we;
  logic              recv_we;
  logic [KEY_W-1:0]  send_wdata;
  logic [KEY_W-1:0]  recv_wdata;
  logic [ADDR_W-1:0] waddr;
  logic [KEY_W-1:0]  send_rdata;
  logic [KEY_W-1:0]  recv_rdata;

  logic [KEY_W-1:0]  key_sel;
  logic [KEY_W-1:0]  key_next;
  logic [DATA_W-1:0] step_out;
  logic              step_odd;

  always_comb begin
    op_in    = opcode_t'(opcode);
    in_stall = rst || (state != S_IDLE);
    accept   = in_valid && !in_stall;
    in_range = (32'(client) < 32'(CLIENTS));
    addr_in  = ADDR_W'(client);
    raddr    = (state == S_IDLE) ? addr_in : addr_q;
    out_free = !out_valid || !out_stall;
    finish   = (state == S_CALC) && out_free;

    key_sel  = (op_q == OP_ENCODE) ? send_rdata : recv_rdata;
    step_odd = (op_q == OP_PEEK) ? 1'b0 : odd_q;

    // loads write at accept, encode and decode words write back at finish
    if (state == S_IDLE) begin
      waddr      = addr_in;
      send_we    = accept && in_range && (op_in == OP_LOAD_SEND);
      recv_we    = accept && in_range && (op_in == OP_LOAD_RECV);
      send_wdata = key_value;
      recv_wdata = key_value;
    end else begin
      waddr      = addr_q;
      send_we    = finish && (op_q == OP_ENCODE);
      recv_we    = finish && (op_q == OP_DECODE);
      send_wdata = key_next;
      recv_wdata = key_next;
    end
  end

  lkx_ram #(
    .WIDTH (KEY_W),
    .DEPTH (CLIENTS),
    .ADDR_W(ADDR_W)
  ) u_send_keys (
    .clk  (clk),
    .we   (send_we),
    .waddr(waddr),
    .wdata(send_wdata),
    .raddr(raddr),
    .rdata(send_rdata)
  );

  lkx_ram #(
    .WIDTH (KEY_W),
    .DEPTH (CLIENTS),
    .ADDR_W(ADDR_W)
  ) u_recv_keys (
    .clk  (clk),
    .we   (recv_we),
    .waddr(waddr),
    .wdata(recv_wdata),
    .raddr(raddr),
    .rdata(recv_rdata)
  );

  lkx_step u_step (
    .key     (key_sel),
    .data_in (data_q),
    .odd_byte(step_odd),
    .key_next(key_next),
    .data_out(step_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept && in_range &&
              (op_in == OP_ENCODE || op_in == OP_DECODE || op_in == OP_PEEK)) begin
            state <= S_CALC;
          end
        end
        S_CALC: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (finish) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q   <= op_in;
      addr_q <= addr_in;
      data_q <= data_in;
      odd_q  <= odd_byte;
    end
    if (finish) begin
      data_out <= step_out;
    end
  end

endmodule

[bench/lcg_keystream_xor_codec_top_test.sv]
// ----------------------------------------------------------------------------
// lcg_keystream_xor_codec_top_test
// self-checking bench for the per-client keystream codec. a short table of
// directed words covers key extremes, odd bytes, peeks, loads and spare
// opcodes, then random load and cipher sequences follow. every result word is
// compared with a local model of the send and receive keys or a fixed value,
// under random gaps on the input side and random stalls on the output side
// ----------------------------------------------------------------------------
module lcg_keystream_xor_codec_top_test;
  import lkx_pkg::*;

  localparam int WORDS = 950;
  localparam int QUIET_LIMIT = 1000;
  localparam logic [2:0] OP_SPARE_5 = 3'd5;
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  typedef struct {
    logic [2:0]        op;
    logic [7:0]        cl;
    logic [DATA_W-1:0] din;
    logic              odd;
    logic [KEY_W-1:0]  kv;
    bit                fixed;
    logic [DATA_W-1:0] want;
  } word_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [2:0]        opcode = '0;
  logic [7:0]        client = '0;
  logic [DATA_W-1:0] data_in = '0;
  logic              odd_byte = 1'b0;
  logic [KEY_W-1:0]  key_value = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [DATA_W-1:0] data_out;

  logic [KEY_W-1:0]  send_key [256];
  logic [KEY_W-1:0]  recv_key [256];
  bit                send_set [256];
  bit                recv_set [256];
  logic [DATA_W-1:0] exp_words [$];
  word_t             plan [$];
  logic [2:0]        data_ops [3] = '{OP_ENCODE, OP_DECODE, OP_PEEK};
  logic [2:0]        spare_ops [3] = '{OP_SPARE_5, OP_SPARE_6, OP_SPARE_7};
  bit                no_idle = 1'b0;
  int                err_cnt = 0;
  int                quiet_cycles = 0;
  int                rx_left = 0;

  lcg_keystream_xor_codec_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .opcode    (opcode),
    .client    (client),
    .data_in   (data_in),
    .odd_byte  (odd_byte),
    .key_value (key_value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .data_out  (data_out)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic flag_error(input string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("mismatch: %s", msg);
  endtask

  // advances the local key copies and gives the cipher word, if any
  task automatic cipher_step(input logic [2:0] op, input logic [7:0] cl,
                             input logic [DATA_W-1:0] din, input logic odd,
                             input logic [KEY_W-1:0] kv, output bit hit,
                             output logic [DATA_W-1:0] res);
    logic [KEY_W-1:0] k;
    hit = 1'b0;
    res = '0;
    case (op)
      OP_ENCODE, OP_DECODE: begin
        k = (op == OP_ENCODE) ? send_key[cl] : recv_key[cl];
        k = k * LCG_MUL + LCG_ADD;
        if (op == OP_ENCODE) send_key[cl] = k;
        else recv_key[cl] = k;
        res = odd ? {8'h00, din[7:0] ^ k[23:16]} : din ^ k[31:16];
        hit = 1'b1;
      end
      OP_PEEK: begin
        k = recv_key[cl] * LCG_MUL + LCG_ADD;
        res = din ^ k[31:16];
        hit = 1'b1;
      end
      OP_LOAD_SEND: begin
        send_key[cl] = kv;
        send_set[cl] = 1'b1;
      end
      OP_LOAD_RECV: begin
        recv_key[cl] = kv;
        recv_set[cl] = 1'b1;
      end
      default: ;
    endcase
  endtask

  task automatic send_word(input word_t w);
    int gap;
    bit hit;
    logic [DATA_W-1:0] res;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    opcode    <= w.op;
    client    <= w.cl;
    data_in   <= w.din;
    odd_byte  <= w.odd;
    key_value <= w.kv;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    cipher_step(w.op, w.cl, w.din, w.odd, w.kv, hit, res);
    if (hit) exp_words.push_back(w.fixed ? w.want : res);
  endtask

  task automatic plan_word(input logic [2:0] op, input logic [7:0] cl,
                           input logic [DATA_W-1:0] din, input logic odd,
                           input logic [KEY_W-1:0] kv, input bit fixed,
                           input logic [DATA_W-1:0] want);
    word_t w;
    w.op = op;
    w.cl = cl;
    w.din = din;
    w.odd = odd;
    w.kv = kv;
    w.fixed = fixed;
    w.want = want;
    plan.push_back(w);
  endtask

  // output side stalls
  always @(posedge clk) begin
    int len;
    if (rst) begin
      out_stall <= 1'b0;
      rx_left = 0;
    end else if (rx_left > 0) begin
      rx_left--;
    end else if (no_idle) begin
      out_stall <= 1'b0;
    end else if (out_stall) begin
      out_stall <= 1'b0;
      rx_left = $urandom_range(0, 6);
    end else begin
      len = pick_gap();
      if (len > 0) begin
        out_stall <= 1'b1;
        rx_left = len - 1;
      end
    end
  end

  // result check and watchdog
  always @(posedge clk) begin
    logic [DATA_W-1:0] want;
    if (!rst && out_valid && !out_stall) begin
      if (exp_words.size() == 0) begin
        flag_error($sformatf("unexpected word data_out=%h", data_out));
      end else begin
        want = exp_words.pop_front();
        if (data_out !== want)
          flag_error($sformatf("data_out expected %h actual %h", want, data_out));
      end
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("lcg_keystream_xor_codec_top_test: errors");
      $finish;
    end
  end

  initial begin : stimulus
    word_t w;
    word_t seed;
    logic [7:0] pool [4];
    int made;
    int pick;
    int pause_at;
    foreach (pool[i]) pool[i] = 8'($urandom_range(0, 255));
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // key zero and all ones give stream words 0026 and 0023
    plan_word(OP_LOAD_SEND, 8'd0,   16'h0000, 1'b0, 32'h0000_0000, 0, '0);
    plan_word(OP_ENCODE,    8'd0,   16'h0000, 1'b0, 32'hffff_ffff, 1, 16'h0026);
    plan_word(OP_LOAD_RECV, 8'd1,   16'hffff, 1'b1, 32'h0000_0000, 0, '0);
    plan_word(OP_PEEK,      8'd1,   16'h0000, 1'b0, 32'h0000_0000, 1, 16'h0026);
    plan_word(OP_PEEK,      8'd1,   16'hffff, 1'b1, 32'h0000_0000, 1, 16'hffd9);
    plan_word(OP_DECODE,    8'd1,   16'hffff, 1'b1, 32'h0000_0000, 1, 16'h00d9);
    plan_word(OP_DECODE,    8'd1,   16'hffff, 1'b0, 32'h0000_0000, 0, '0);
    plan_word(OP_LOAD_SEND, 8'd255, 16'h0000, 1'b0, 32'hffff_ffff, 0, '0);
    plan_word(OP_ENCODE,    8'd255, 16'hffff, 1'b0, 32'h0000_0000, 1, 16'hffdc);
    plan_word(OP_LOAD_RECV, 8'd255, 16'h0000, 1'b0, 32'hffff_ffff, 0, '0);
    plan_word(OP_DECODE,    8'd255, 16'h00ff, 1'b1, 32'h0000_0000, 1, 16'h00dc);
    plan_word(OP_SPARE_5,   8'd0,   16'hffff, 1'b1, 32'hffff_ffff, 0, '0);
    plan_word(OP_SPARE_6,   8'd255, 16'hffff, 1'b0, 32'h0000_0000, 0, '0);
    plan_word(OP_SPARE_7,   8'd1,   16'h0000, 1'b1, 32'hffff_ffff, 0, '0);
    plan_word(OP_ENCODE,    8'd0,   16'ha5a5, 1'b1, 32'h0000_0000, 0, '0);
    plan_word(OP_LOAD_SEND, 8'd0,   16'h0000, 1'b0, 32'h1234_5678, 0, '0);
    plan_word(OP_ENCODE,    8'd0,   16'h5a5a, 1'b0, 32'h0000_0000, 0, '0);
    plan_word(OP_ENCODE,    8'd0,   16'hffff, 1'b0, 32'h0000_0000, 0, '0);
    plan_word(OP_LOAD_RECV, 8'd0,   16'h0000, 1'b0, 32'h8000_0001, 0, '0);
    plan_word(OP_DECODE,    8'd0,   16'h0000, 1'b0, 32'h0000_0000, 0, '0);
    plan_word(OP_PEEK,      8'd0,   16'h1234, 1'b0, 32'h0000_0000, 0, '0);
    plan_word(OP_DECODE,    8'd0,   16'h0000, 1'b1, 32'h0000_0000, 0, '0);
    plan_word(OP_PEEK,      8'd255, 16'h0000, 1'b1, 32'h0000_0000, 0, '0);
    plan_word(OP_LOAD_SEND, 8'd255, 16'h0000, 1'b0, 32'h0000_0000, 0, '0);
    plan_word(OP_ENCODE,    8'd255, 16'h0000, 1'b0, 32'h0000_0000, 1, 16'h0026);
    foreach (plan[i]) send_word(plan[i]);

    made = 0;
    pause_at = 300;
    while (made < WORDS) begin
      // let the codec run dry before carrying on
      if (made >= pause_at) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (exp_words.size() != 0);
        pause_at += 400;
      end
      no_idle = (made >= 400 && made < 520);
      pick = $urandom_range(0, 99);
      w.cl = ($urandom_range(0, 9) < 7) ? pool[$urandom_range(0, 3)]
                                        : 8'($urandom_range(0, 255));
      w.din = 16'($urandom_range(0, 65535));
      w.odd = ($urandom_range(0, 6) == 0);
      w.kv = $urandom;
      if ($urandom_range(0, 9) == 0) w.kv = $urandom_range(0, 1) ? '1 : '0;
      w.fixed = 1'b0;
      w.want = '0;
      if (pick < 4) begin
        w.op = spare_ops[$urandom_range(0, 2)];
      end else if (pick < 12) begin
        w.op = OP_LOAD_SEND;
      end else if (pick < 20) begin
        w.op = OP_LOAD_RECV;
      end else begin
        w.op = data_ops[$urandom_range(0, 2)];
        if ((w.op == OP_ENCODE) ? !send_set[w.cl] : !recv_set[w.cl]) begin
          seed = w;
          seed.op = (w.op == OP_ENCODE) ? OP_LOAD_SEND : OP_LOAD_RECV;
          seed.kv = $urandom;
          send_word(seed);
          made++;
        end
      end
      send_word(w);
      if (pick >= 4) made++;
    end
    no_idle = 1'b0;
    in_valid <= 1'b0;

    while (exp_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (err_cnt == 0) begin
      $display("lcg_keystream_xor_codec_top_test: clean");
    end else begin
      $display("lcg_keystream_xor_codec_top_test: errors");
    end
    $finish;
  end

endmodule
